// ===== design/class_wise_box_nms_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the class-wise box suppression block
// Shorthand for clocked implications, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef CLASS_WISE_BOX_NMS_ASSERT_SVH
`define CLASS_WISE_BOX_NMS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWBN_ASSERT_HOLDS(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CWBN_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/cwbn_pkg.sv =====
// ----------------------------------------------------------------------------
// cwbn_pkg
// Shared types and constants of the class-wise box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwbn_pkg;

    localparam int MAX_BOXES_DEF   = 64;
    localparam int NUM_CLASSES_DEF = 8;
    localparam logic [15:0] THR_RESET = 16'd29491;

    // One classified load transfer handed from the front to the back.
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
        logic [2:0]  cls;
        logic        store;
        logic        ovf;
        logic        last;
    } box_cmd_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
        logic [2:0]  cls;
        logic        end_flag;
        logic        dropped;
    } kept_box_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_SELW,
        ST_EMIT,
        ST_SUP,
        ST_SUPW,
        ST_FINAL,
        ST_CLEAR
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/cwbn_front.sv =====
// ----------------------------------------------------------------------------
// cwbn_front
// Accepts load transfers, filters the class, assigns slots and counts the set.
// ----------------------------------------------------------------------------
`default_nettype none

module cwbn_front
    import cwbn_pkg::*;
#(
    parameter int MAX_BOXES   = MAX_BOXES_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    localparam int CW = $clog2(MAX_BOXES + 1),
    localparam int IW = $clog2(MAX_BOXES)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [79:0]   s_axis_tdata,
    input  wire logic [2:0]    s_axis_tuser,
    input  wire logic          s_axis_tlast,
    input  wire logic          q_full,
    output logic               q_wr_valid,
    output box_cmd_t           q_cmd,
    output logic [IW-1:0]      q_slot,
    output logic [CW-1:0]      q_total
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          accept;
    logic          in_range;
    logic          cap_full;
    logic          do_store;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign in_range      = ({1'b0, s_axis_tuser} < 4'(NUM_CLASSES));
    assign cap_full      = (count_reg == CW'(MAX_BOXES));
    assign do_store      = in_range && !cap_full;

    assign q_wr_valid   = accept;
    assign q_cmd.left   = s_axis_tdata[15:0];
    assign q_cmd.top    = s_axis_tdata[31:16];
    assign q_cmd.right  = s_axis_tdata[47:32];
    assign q_cmd.bottom = s_axis_tdata[63:48];
    assign q_cmd.score  = s_axis_tdata[79:64];
    assign q_cmd.cls    = s_axis_tuser;
    assign q_cmd.store  = do_store;
    assign q_cmd.ovf    = in_range && cap_full;
    assign q_cmd.last   = s_axis_tlast;
    assign q_slot       = count_reg[IW-1:0];
    assign q_total      = count_reg + CW'(do_store);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = s_axis_tlast ? '0 : q_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/cwbn_queue.sv =====
// ----------------------------------------------------------------------------
// cwbn_queue
// Two-entry queue that decouples the load front from the suppression back.
// ----------------------------------------------------------------------------
`default_nettype none

module cwbn_queue
    import cwbn_pkg::*;
#(
    parameter int W = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_valid,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         rd_pop,
    output logic [W-1:0]      rd_data,
    output logic              empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;
    logic         do_wr;
    logic         do_rd;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign do_wr   = wr_valid && !full;
    assign do_rd   = rd_pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

`default_nettype wire

// ===== design/cwbn_back.sv =====
// ----------------------------------------------------------------------------
// cwbn_back
// Stores the set, picks boxes in visiting order and suppresses overlaps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "class_wise_box_nms_assert.svh"

module cwbn_back
    import cwbn_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    localparam int CW = $clog2(MAX_BOXES + 1),
    localparam int IW = $clog2(MAX_BOXES)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire box_cmd_t      q_cmd,
    input  wire logic [IW-1:0] q_slot,
    input  wire logic [CW-1:0] q_total,
    output logic               q_pop,
    input  wire logic          thr_we,
    input  wire logic [15:0]   thr_wdata,
    output logic               out_valid,
    input  wire logic          out_ready,
    output kept_box_t          out_box
);

    function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
        span16 = (hi > lo) ? (hi - lo) : 16'd0;
    endfunction

    function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
        max16 = (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        min16 = (a < b) ? a : b;
    endfunction

    back_state_t state_reg;
    back_state_t state_next;

    logic [63:0] corner_mem [MAX_BOXES];
    logic [18:0] sc_mem [MAX_BOXES];

    logic [15:0]          thr_reg;
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        n_m1;
    logic [IW-1:0]        cnt_reg;
    logic                 ovf_reg;
    logic [MAX_BOXES-1:0] done_reg;

    logic          s1_valid_reg;
    logic [IW-1:0] s1_idx_reg;
    logic [63:0]   rd_corner_reg;
    logic [18:0]   rd_sc_reg;

    logic          have_best_reg;
    logic [IW-1:0] best_idx_reg;
    logic [63:0]   best_corner_reg;
    logic [18:0]   best_sc_reg;

    logic          pend_valid_reg;
    logic [63:0]   pend_corner_reg;
    logic [18:0]   pend_sc_reg;

    logic          out_valid_reg;
    kept_box_t     out_box_reg;

    logic          s2_valid_reg;
    logic [IW-1:0] s2_idx_reg;
    logic [15:0]   iw_reg, ih_reg, wp_reg, hp_reg, wq_reg, hq_reg;
    logic          s3_valid_reg;
    logic [IW-1:0] s3_idx_reg;
    logic [31:0]   inter3_reg, ap_reg, aq_reg;
    logic          s4_valid_reg;
    logic [IW-1:0] s4_idx_reg;
    logic [31:0]   inter4_reg;
    logic [32:0]   uni_reg;

    logic issue, last_issue, sel_start, mark_best, load_pend, push_out, push_end;
    logic clear_set, out_free, sup_phase, sel_phase, pipe_busy;
    logic cand_sel, better, cand_sup, suppress;
    logic [48:0] thr_uni;

    assign n_m1       = n_reg - CW'(1);
    assign last_issue = (cnt_reg == n_m1[IW-1:0]);
    assign out_free   = !out_valid_reg || out_ready;
    assign sup_phase  = (state_reg == ST_SUP) || (state_reg == ST_SUPW);
    assign sel_phase  = (state_reg == ST_SEL) || (state_reg == ST_SELW);
    assign pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    // Scan order is ascending, so a strict compare keeps the earlier slot on a tie.
    assign cand_sel = !done_reg[s1_idx_reg];
    assign better   = !have_best_reg || (rd_sc_reg[18:16] < best_sc_reg[18:16])
                      || ((rd_sc_reg[18:16] == best_sc_reg[18:16])
                          && (rd_sc_reg[15:0] > best_sc_reg[15:0]));
    assign cand_sup = !done_reg[s1_idx_reg] && (rd_sc_reg[18:16] == best_sc_reg[18:16]);

    assign thr_uni  = {33'd0, thr_reg} * {16'd0, uni_reg};
    assign suppress = (uni_reg != 33'd0) && ({1'b0, inter4_reg, 16'd0} > thr_uni);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        issue      = 1'b0;
        sel_start  = 1'b0;
        mark_best  = 1'b0;
        load_pend  = 1'b0;
        push_out   = 1'b0;
        push_end   = 1'b0;
        clear_set  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.last)
                    begin
                        if (q_total == '0)
                        begin
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            sel_start  = 1'b1;
                            state_next = ST_SEL;
                        end
                    end
                end
            end
            ST_SEL:
            begin
                issue = 1'b1;
                if (last_issue)
                begin
                    state_next = ST_SELW;
                end
            end
            ST_SELW:
            begin
                if (!s1_valid_reg)
                begin
                    if (have_best_reg)
                    begin
                        mark_best = 1'b1;
                        if (pend_valid_reg)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            load_pend  = 1'b1;
                            state_next = ST_SUP;
                        end
                    end
                    else
                    begin
                        state_next = pend_valid_reg ? ST_FINAL : ST_CLEAR;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    push_out   = 1'b1;
                    load_pend  = 1'b1;
                    state_next = ST_SUP;
                end
            end
            ST_SUP:
            begin
                issue = 1'b1;
                if (last_issue)
                begin
                    state_next = ST_SUPW;
                end
            end
            ST_SUPW:
            begin
                if (!pipe_busy)
                begin
                    sel_start  = 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    push_out   = 1'b1;
                    push_end   = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                clear_set  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Box store and registered read port.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.store)
        begin
            corner_mem[q_slot] <= {q_cmd.bottom, q_cmd.right, q_cmd.top, q_cmd.left};
            sc_mem[q_slot]     <= {q_cmd.cls, q_cmd.score};
        end
        if (issue)
        begin
            rd_corner_reg <= corner_mem[cnt_reg];
            rd_sc_reg     <= sc_mem[cnt_reg];
            s1_idx_reg    <= cnt_reg;
        end
    end

    // Payload registers of the selection and the overlap pipeline.
    always_ff @(posedge clk)
    begin
        if (sel_phase && s1_valid_reg && cand_sel && better)
        begin
            best_idx_reg    <= s1_idx_reg;
            best_corner_reg <= rd_corner_reg;
            best_sc_reg     <= rd_sc_reg;
        end
        if (load_pend)
        begin
            pend_corner_reg <= best_corner_reg;
            pend_sc_reg     <= best_sc_reg;
        end
        if (push_out)
        begin
            out_box_reg.left     <= pend_corner_reg[15:0];
            out_box_reg.top      <= pend_corner_reg[31:16];
            out_box_reg.right    <= pend_corner_reg[47:32];
            out_box_reg.bottom   <= pend_corner_reg[63:48];
            out_box_reg.score    <= pend_sc_reg[15:0];
            out_box_reg.cls      <= pend_sc_reg[18:16];
            out_box_reg.end_flag <= push_end;
            out_box_reg.dropped  <= ovf_reg;
        end
        s2_idx_reg <= s1_idx_reg;
        iw_reg <= span16(max16(best_corner_reg[15:0], rd_corner_reg[15:0]),
                         min16(best_corner_reg[47:32], rd_corner_reg[47:32]));
        ih_reg <= span16(max16(best_corner_reg[31:16], rd_corner_reg[31:16]),
                         min16(best_corner_reg[63:48], rd_corner_reg[63:48]));
        wp_reg <= span16(best_corner_reg[15:0], best_corner_reg[47:32]);
        hp_reg <= span16(best_corner_reg[31:16], best_corner_reg[63:48]);
        wq_reg <= span16(rd_corner_reg[15:0], rd_corner_reg[47:32]);
        hq_reg <= span16(rd_corner_reg[31:16], rd_corner_reg[63:48]);
        s3_idx_reg <= s2_idx_reg;
        inter3_reg <= {16'd0, iw_reg} * {16'd0, ih_reg};
        ap_reg     <= {16'd0, wp_reg} * {16'd0, hp_reg};
        aq_reg     <= {16'd0, wq_reg} * {16'd0, hq_reg};
        s4_idx_reg <= s3_idx_reg;
        inter4_reg <= inter3_reg;
        uni_reg    <= {1'b0, ap_reg} + {1'b0, aq_reg} - {1'b0, inter3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            n_reg          <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            have_best_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (thr_we)
            begin
                thr_reg <= thr_wdata;
            end
            if (q_pop)
            begin
                if (q_cmd.ovf)
                begin
                    ovf_reg <= 1'b1;
                end
                if (q_cmd.last)
                begin
                    n_reg <= q_total;
                end
            end
            if (issue)
            begin
                cnt_reg <= last_issue ? '0 : cnt_reg + IW'(1);
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= sup_phase && s1_valid_reg && cand_sup;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (sel_start)
            begin
                have_best_reg <= 1'b0;
            end
            else if (sel_phase && s1_valid_reg && cand_sel)
            begin
                have_best_reg <= 1'b1;
            end
            if (load_pend)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mark_best)
            begin
                done_reg[best_idx_reg] <= 1'b1;
            end
            if (s4_valid_reg && suppress)
            begin
                done_reg[s4_idx_reg] <= 1'b1;
            end
            if (clear_set)
            begin
                done_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_box   = out_box_reg;

    `CWBN_ASSERT_HOLDS(a_sup_has_pend, clk, rst_n, state_reg == ST_SUP, pend_valid_reg)
    `CWBN_ASSERT_HOLDS(a_idle_pipe_empty, clk, rst_n, state_reg == ST_IDLE, !pipe_busy)
    `CWBN_ASSERT_NEXT(a_final_end, clk, rst_n, (state_reg == ST_FINAL) && out_free, out_valid_reg && out_box_reg.end_flag)

endmodule

`default_nettype wire

// ===== design/class_wise_box_nms.sv =====
// ----------------------------------------------------------------------------
// class_wise_box_nms
// Class-wise greedy non-maximum suppression over a loaded set of boxes.
// ----------------------------------------------------------------------------
// Boxes are loaded one transfer per cycle while the queue is not full, through
// a two-entry queue; a transfer with tlast starts suppression. For a set of n
// stored boxes of which k are kept, the back end runs k rounds: each round
// scans the box memory once through its single read port to pick the next box
// in visiting order, then scans it again through a four-stage overlap
// pipeline, and a final scan finds no box left. While a set is being suppressed
// the input stalls once the queue is full. Results leave by class ascending and
// score descending, tlast marking the last kept box.
`default_nettype none

module class_wise_box_nms
    import cwbn_pkg::*;
#(
    parameter int MAX_BOXES   = MAX_BOXES_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        iou_threshold_we,
    input  wire logic [15:0] iou_threshold_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // box_left, box_top, box_right, box_bottom, box_score
    input  wire logic [79:0] s_axis_tdata,
    // box_class
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // kept_left, kept_top, kept_right, kept_bottom, kept_score
    output logic [79:0]      m_axis_tdata,
    // kept_class, dropped_any
    output logic [3:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int IW = $clog2(MAX_BOXES);
    localparam int QW = $bits(box_cmd_t) + IW + CW;

    box_cmd_t      f_cmd;
    logic [IW-1:0] f_slot;
    logic [CW-1:0] f_total;
    logic          f_wr;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic [QW-1:0] q_rd;
    box_cmd_t      b_cmd;
    logic [IW-1:0] b_slot;
    logic [CW-1:0] b_total;
    kept_box_t     res;

    cwbn_front #(
        .MAX_BOXES   (MAX_BOXES),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_wr_valid    (f_wr),
        .q_cmd         (f_cmd),
        .q_slot        (f_slot),
        .q_total       (f_total)
    );

    cwbn_queue #(
        .W (QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_wr),
        .wr_data  ({f_slot, f_total, f_cmd}),
        .full     (q_full),
        .rd_pop   (q_pop),
        .rd_data  (q_rd),
        .empty    (q_empty)
    );

    assign b_cmd   = q_rd[$bits(box_cmd_t)-1:0];
    assign b_total = q_rd[$bits(box_cmd_t) +: CW];
    assign b_slot  = q_rd[$bits(box_cmd_t) + CW +: IW];

    cwbn_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (b_cmd),
        .q_slot    (b_slot),
        .q_total   (b_total),
        .q_pop     (q_pop),
        .thr_we    (iou_threshold_we),
        .thr_wdata (iou_threshold_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_box   (res)
    );

    assign m_axis_tdata = {res.score, res.bottom, res.right, res.top, res.left};
    assign m_axis_tuser = {res.dropped, res.cls};
    assign m_axis_tlast = res.end_flag;

endmodule

`default_nettype wire
